>>> hw/rtl/odo_pkg.sv
// Package for the odometry pose integrator: payload and command types,
// fixed-point constants and the CORDIC arctangent table.
// No dependencies; used by every other file of the block.
package odo_pkg;

  // Configuration
  localparam int unsigned MAXLIN_W = 15;
  localparam logic [MAXLIN_W-1:0] MAXLIN_RESET = 15'd22733;  // 5.55 m/s in Q4.12

  // Item kind codes
  localparam logic FUNC_CMD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // CORDIC
  localparam int unsigned TRIG_ITERATIONS = 16;
  localparam int unsigned ATAN_LEN        = 24;
  localparam int unsigned CORDIC_STEPS    =
    (TRIG_ITERATIONS < ATAN_LEN) ? TRIG_ITERATIONS : ATAN_LEN;
  localparam int unsigned ITER_W          = $clog2(CORDIC_STEPS);
  localparam int unsigned ATAN_IDX_W      = 5;
  localparam int unsigned ATAN_W          = 30;
  localparam int unsigned CW              = 33;  // CORDIC x, y, z width
  localparam logic [CW-1:0] CORDIC_X0     = 33'd652032874;  // 2^30 over CORDIC gain

  // Shared multiplier
  localparam int unsigned MW     = 33;
  localparam int unsigned PROD_W = 2 * MW;
  localparam logic [ATAN_W-1:0] TURN_PER_RAD_Q32 = 30'd683565276;  // 2^32 / (2 pi)

  // Rounding offsets on the product
  localparam logic [PROD_W-1:0] FINE_HALF = PROD_W'(1) << 27;
  localparam logic [PROD_W-1:0] DXY_HALF  = PROD_W'(1) << 41;
  localparam int unsigned FINE_W = 34;
  localparam int unsigned DXY_W  = 24;

  typedef struct packed {
    logic               func;
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic [15:0]        elapsed;
  } odo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [15:0] linear_vel;
    logic signed [15:0] angular_vel;
  } odo_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WDT,
    ST_DS,
    ST_FINE,
    ST_ANGLE,
    ST_CORDIC,
    ST_MULX,
    ST_MULY,
    ST_UPDATE
  } odo_state_e;

  typedef enum logic [2:0] {
    MUL_ANG_DT,
    MUL_LIN_DT,
    MUL_WDT_K,
    MUL_DS_COS,
    MUL_DS_SIN
  } mul_sel_e;

  typedef struct packed {
    logic                  load_cmd;
    logic                  load_tick;
    logic                  mul_en;
    mul_sel_e              mul_sel;
    logic                  angle_en;
    logic                  cordic_en;
    logic [ATAN_IDX_W-1:0] iter;
    logic                  update_en;
  } odo_cmd_t;

  typedef struct packed {
    logic out_busy;
  } odo_stat_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [ATAN_W-1:0] atan_turn32(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] r;
    unique case (idx)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41722;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2608;
      5'd19:   r = 30'd1304;
      5'd20:   r = 30'd652;
      5'd21:   r = 30'd326;
      5'd22:   r = 30'd163;
      5'd23:   r = 30'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Signed 32-bit saturating add of a position step
  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [DXY_W-1:0] d);
    logic signed [32:0] sum;
    logic signed [31:0] r;
    sum = 33'(a) + 33'(d);
    if (sum[32] != sum[31]) begin
      r = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = sum[31:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/odo_in_if.sv
// Input item channel of the odometry pose integrator.
// Depends on odo_pkg for the payload type.
interface odo_in_if;
  logic            valid;
  logic            ready;
  odo_pkg::odo_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/odo_out_if.sv
// Result item channel of the odometry pose integrator.
// Depends on odo_pkg for the payload type.
interface odo_out_if;
  logic             valid;
  logic             ready;
  odo_pkg::odo_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/odo_ctrl.sv
// Sequencer for the odometry pose integrator: walks a tick item through
// multiply, angle, CORDIC and update steps. Depends on odo_pkg.
module odo_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_func_i,
  output logic                in_ready_o,
  input  odo_pkg::odo_stat_t  stat_i,
  output odo_pkg::odo_cmd_t   cmd_o
);

  localparam logic [odo_pkg::ITER_W-1:0] ITER_LAST =
    odo_pkg::ITER_W'(odo_pkg::CORDIC_STEPS - 1);

  odo_pkg::odo_state_e state_q, state_d;
  logic [odo_pkg::ITER_W-1:0] iter_q, iter_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= odo_pkg::ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    unique case (state_q)
      odo_pkg::ST_IDLE: begin
        if (in_valid_i && (in_func_i == odo_pkg::FUNC_TICK)) begin
          state_d = odo_pkg::ST_WDT;
        end
      end
      odo_pkg::ST_WDT:   state_d = odo_pkg::ST_DS;
      odo_pkg::ST_DS:    state_d = odo_pkg::ST_FINE;
      odo_pkg::ST_FINE:  state_d = odo_pkg::ST_ANGLE;
      odo_pkg::ST_ANGLE: begin
        state_d = odo_pkg::ST_CORDIC;
        iter_d  = '0;
      end
      odo_pkg::ST_CORDIC: begin
        if (iter_q == ITER_LAST) begin
          state_d = odo_pkg::ST_MULX;
          iter_d  = '0;
        end else begin
          iter_d = iter_q + odo_pkg::ITER_W'(1);
        end
      end
      odo_pkg::ST_MULX: state_d = odo_pkg::ST_MULY;
      odo_pkg::ST_MULY: state_d = odo_pkg::ST_UPDATE;
      odo_pkg::ST_UPDATE: begin
        if (!stat_i.out_busy) begin
          state_d = odo_pkg::ST_IDLE;
        end
      end
      default: state_d = odo_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.mul_sel = odo_pkg::MUL_ANG_DT;
    cmd_o.iter    = odo_pkg::ATAN_IDX_W'(iter_q);
    unique case (state_q)
      odo_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_cmd  = in_valid_i && (in_func_i == odo_pkg::FUNC_CMD);
        cmd_o.load_tick = in_valid_i && (in_func_i == odo_pkg::FUNC_TICK);
      end
      odo_pkg::ST_WDT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = odo_pkg::MUL_ANG_DT;
      end
      odo_pkg::ST_DS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = odo_pkg::MUL_LIN_DT;
      end
      odo_pkg::ST_FINE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = odo_pkg::MUL_WDT_K;
      end
      odo_pkg::ST_ANGLE:  cmd_o.angle_en  = 1'b1;
      odo_pkg::ST_CORDIC: cmd_o.cordic_en = 1'b1;
      odo_pkg::ST_MULX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = odo_pkg::MUL_DS_COS;
      end
      odo_pkg::ST_MULY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = odo_pkg::MUL_DS_SIN;
      end
      odo_pkg::ST_UPDATE: cmd_o.update_en = !stat_i.out_busy;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/odo_datapath.sv
// Datapath of the odometry pose integrator: pose and velocity state, shared
// multiplier, CORDIC unit and result register. Depends on odo_pkg.
module odo_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [odo_pkg::MAXLIN_W-1:0]     cfg_data_i,
  input  odo_pkg::odo_in_t                 in_data_i,
  input  odo_pkg::odo_cmd_t                cmd_i,
  output odo_pkg::odo_stat_t               stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output odo_pkg::odo_out_t                out_data_o
);

  localparam int unsigned CW = odo_pkg::CW;
  localparam int unsigned MW = odo_pkg::MW;
  localparam int unsigned PW = odo_pkg::PROD_W;

  // Architectural state
  logic [odo_pkg::MAXLIN_W-1:0] maxlin_q;
  logic signed [15:0] lin_goal_q, ang_goal_q;
  logic signed [31:0] x_acc_q, y_acc_q;
  logic [15:0]        yaw_q;

  // Working registers of one tick
  logic [15:0]          dt_q;
  logic signed [31:0]   wdt_q, ds_q;
  logic signed [PW-1:0] prod_q;
  logic [15:0]          dyaw_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [1:0]           quad_q;
  logic signed [odo_pkg::DXY_W-1:0] dx_q;

  logic              out_valid_q;
  odo_pkg::odo_out_t out_data_q;

  // Linear command clamp
  logic signed [16:0] lim_v, lin_v;
  logic signed [15:0] lin_clamp;
  always_comb begin
    lim_v = $signed({2'b00, maxlin_q});
    lin_v = 17'(in_data_i.linear_cmd);
    if (lin_v > lim_v) begin
      lin_clamp = lim_v[15:0];
    end else if (lin_v < -lim_v) begin
      lin_clamp = 16'(-lim_v);
    end else begin
      lin_clamp = lin_v[15:0];
    end
  end

  // Quadrant fold of the CORDIC result
  logic signed [CW-1:0] cos_v, sin_v;
  always_comb begin
    unique case (quad_q)
      2'd0: begin cos_v = cx_q;  sin_v = cy_q;  end
      2'd1: begin cos_v = -cy_q; sin_v = cx_q;  end
      2'd2: begin cos_v = -cx_q; sin_v = -cy_q; end
      default: begin cos_v = cy_q; sin_v = -cx_q; end
    endcase
  end

  // Shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  always_comb begin
    unique case (cmd_i.mul_sel)
      odo_pkg::MUL_ANG_DT: begin
        mul_a = MW'(ang_goal_q);
        mul_b = $signed(MW'(dt_q));
      end
      odo_pkg::MUL_LIN_DT: begin
        mul_a = MW'(lin_goal_q);
        mul_b = $signed(MW'(dt_q));
      end
      odo_pkg::MUL_WDT_K: begin
        mul_a = MW'(wdt_q);
        mul_b = $signed(MW'(odo_pkg::TURN_PER_RAD_Q32));
      end
      odo_pkg::MUL_DS_COS: begin
        mul_a = MW'(ds_q);
        mul_b = cos_v;
      end
      odo_pkg::MUL_DS_SIN: begin
        mul_a = MW'(ds_q);
        mul_b = sin_v;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Heading step from w*dt*K: round to 2^-32 turn, then split into the
  // midpoint angle and the rounded 2^-16 turn heading step
  logic signed [PW-1:0] fine_sum;
  logic signed [odo_pkg::FINE_W-1:0] fine_v, dyaw_sum;
  logic [31:0] mid_v;
  assign fine_sum = prod_q + $signed(odo_pkg::FINE_HALF);
  assign fine_v   = fine_sum[61:28];
  assign dyaw_sum = fine_v + odo_pkg::FINE_W'(32768);
  assign mid_v    = {yaw_q, 16'h0000} + fine_v[32:1];

  // Round product by 2^-42 for the position step
  logic signed [PW-1:0] dxy_sum;
  logic signed [odo_pkg::DXY_W-1:0] dxy_v;
  assign dxy_sum = prod_q + $signed(odo_pkg::DXY_HALF);
  assign dxy_v   = dxy_sum[PW-1:PW-odo_pkg::DXY_W];

  // One CORDIC rotation step
  logic signed [CW-1:0] xs_v, ys_v, atan_v;
  assign xs_v   = cx_q >>> cmd_i.iter;
  assign ys_v   = cy_q >>> cmd_i.iter;
  assign atan_v = $signed(CW'(odo_pkg::atan_turn32(cmd_i.iter)));

  // Next pose
  logic signed [31:0] x_nxt, y_nxt;
  logic [15:0]        yaw_nxt;
  assign x_nxt   = odo_pkg::sat_add32(x_acc_q, dx_q);
  assign y_nxt   = odo_pkg::sat_add32(y_acc_q, dxy_v);
  assign yaw_nxt = yaw_q + dyaw_q;

  // State with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxlin_q    <= odo_pkg::MAXLIN_RESET;
      lin_goal_q  <= '0;
      ang_goal_q  <= '0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      yaw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        maxlin_q <= cfg_data_i;
      end
      if (cmd_i.load_cmd) begin
        lin_goal_q <= lin_clamp;
        ang_goal_q <= in_data_i.angular_cmd;
      end
      if (cmd_i.update_en) begin
        x_acc_q     <= x_nxt;
        y_acc_q     <= y_nxt;
        yaw_q       <= yaw_nxt;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tick) begin
      dt_q <= in_data_i.elapsed;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
      // capture the product of the previous step before it is replaced
      if (cmd_i.mul_sel == odo_pkg::MUL_LIN_DT) begin
        wdt_q <= prod_q[31:0];
      end
      if (cmd_i.mul_sel == odo_pkg::MUL_WDT_K) begin
        ds_q <= prod_q[31:0];
      end
      if (cmd_i.mul_sel == odo_pkg::MUL_DS_SIN) begin
        dx_q <= dxy_v;
      end
    end
    if (cmd_i.angle_en) begin
      dyaw_q <= dyaw_sum[31:16];
      quad_q <= mid_v[31:30];
      cx_q   <= $signed(odo_pkg::CORDIC_X0);
      cy_q   <= '0;
      cz_q   <= $signed(CW'(mid_v[29:0]));
    end
    if (cmd_i.cordic_en) begin
      if (!cz_q[CW-1]) begin
        cx_q <= cx_q - ys_v;
        cy_q <= cy_q + xs_v;
        cz_q <= cz_q - atan_v;
      end else begin
        cx_q <= cx_q + ys_v;
        cy_q <= cy_q - xs_v;
        cz_q <= cz_q + atan_v;
      end
    end
    if (cmd_i.update_en) begin
      out_data_q.pos_x       <= x_nxt;
      out_data_q.pos_y       <= y_nxt;
      out_data_q.heading     <= yaw_nxt;
      out_data_q.linear_vel  <= lin_goal_q;
      out_data_q.angular_vel <= ang_goal_q;
    end
  end

  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update_en |-> !(out_valid_q && !out_ready_i))
    else $error("pending result overwritten");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update_en |=> out_valid_q)
    else $error("update did not present a result");

  a_yaw_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.update_en |=> $stable(yaw_q) && $stable(x_acc_q) && $stable(y_acc_q))
    else $error("pose changed outside an update");

endmodule

>>> hw/rtl/odometry_pose_integrator.sv
// Odometry pose integrator: top level joining the sequencer and the datapath.
// Command item: no result; the next item can be taken the cycle after.
// Tick item: WDT, DS, FINE, ANGLE, 16 CORDIC steps, MULX, MULY, then UPDATE
// registers the result (iterative CORDIC, one shared multiplier); a new item
// is taken once idle again. A waiting result stalls only the
// update step. Reset (async, active low) clears the pose and velocities and
// loads the speed limit with 5.55 m/s. Depends on odo_pkg and the interfaces.
module odometry_pose_integrator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [odo_pkg::MAXLIN_W-1:0] cfg_data_i,
  odo_in_if.sink                       in_i,
  odo_out_if.source                    out_o
);

  odo_pkg::odo_cmd_t  cmd;
  odo_pkg::odo_stat_t stat;

  // Sequencer: holds ready high only while idle, steps a tick item through
  // the multiply, angle, CORDIC and update phases
  odo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.data.func),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: velocity goals, pose accumulators and the result register
  odo_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule
